[rtl/ipcpfx_pkg.sv]
// Shared types, constants and AES helper functions for the prefix-preserving
// address cipher. No dependencies.
package ipcpfx_pkg;

    // datapath commands issued by the controller
    typedef enum logic [2:0] {
        OP_NONE,
        OP_LOAD,
        OP_KEY,
        OP_FIX,
        OP_START,
        OP_ROUND,
        OP_BIT,
        OP_OUT
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_FIX,
        ST_START,
        ST_ROUND,
        ST_BITS,
        ST_FINISH
    } state_t;

    typedef struct packed {
        op_t        op;
        logic [3:0] rnd;
        logic       last;
    } cmd_t;

    typedef struct packed {
        logic mapped;
        logic out_valid;
    } sts_t;

    localparam logic [3:0]   LAST_ROUND   = 4'd9;
    localparam logic [3:0]   CHECK_ROUND  = 4'd4;
    localparam logic [7:0]   STEPS_V6     = 8'd128;
    localparam logic [7:0]   STEPS_V4     = 8'd32;
    localparam logic [7:0]   KEY_TWEAK    = 8'h5a;
    localparam logic [127:0] P_INIT_V6    = 128'h1;
    localparam logic [127:0] P_INIT_V4    = 128'h0000_0001_0000_0000_0000_0000_0000_ffff;
    localparam logic [31:0]  V4_MARK      = 32'h0000_ffff;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    function automatic logic [7:0] sbox(input logic [7:0] x);
        return SBOX[x];
    endfunction

    function automatic logic [7:0] rcon(input logic [3:0] idx);
        logic [7:0] r;
        case (idx)
            4'd0:    r = 8'h01;
            4'd1:    r = 8'h02;
            4'd2:    r = 8'h04;
            4'd3:    r = 8'h08;
            4'd4:    r = 8'h10;
            4'd5:    r = 8'h20;
            4'd6:    r = 8'h40;
            4'd7:    r = 8'h80;
            4'd8:    r = 8'h1b;
            4'd9:    r = 8'h36;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    // next round key from the current one
    function automatic logic [127:0] key_next(input logic [127:0] rk, input logic [3:0] idx);
        logic [31:0] t;
        logic [31:0] w0;
        logic [31:0] w1;
        logic [31:0] w2;
        logic [31:0] w3;
        t  = {sbox(rk[23:16]) ^ rcon(idx), sbox(rk[15:8]), sbox(rk[7:0]), sbox(rk[31:24])};
        w0 = rk[127:96] ^ t;
        w1 = rk[95:64] ^ w0;
        w2 = rk[63:32] ^ w1;
        w3 = rk[31:0] ^ w2;
        return {w0, w1, w2, w3};
    endfunction

    // one AES round; byte 0 sits in the top bits
    function automatic logic [127:0] aes_round(input logic [127:0] st, input logic [127:0] rk,
                                               input logic last);
        logic [7:0]   s [16];
        logic [7:0]   t [16];
        logic [7:0]   a0;
        logic [7:0]   a1;
        logic [7:0]   a2;
        logic [7:0]   a3;
        logic [7:0]   all;
        logic [127:0] o;
        for (int i = 0; i < 16; i++) begin
            s[i] = st[127-8*i -: 8];
        end
        for (int c = 0; c < 4; c++) begin
            for (int i = 0; i < 4; i++) begin
                t[i+4*c] = sbox(s[i+4*((c+i)%4)]);
            end
        end
        if (!last) begin
            for (int c = 0; c < 4; c++) begin
                a0  = t[4*c];
                a1  = t[4*c+1];
                a2  = t[4*c+2];
                a3  = t[4*c+3];
                all = a0 ^ a1 ^ a2 ^ a3;
                t[4*c]   = a0 ^ all ^ xtime(a0 ^ a1);
                t[4*c+1] = a1 ^ all ^ xtime(a1 ^ a2);
                t[4*c+2] = a2 ^ all ^ xtime(a2 ^ a3);
                t[4*c+3] = a3 ^ all ^ xtime(a3 ^ a0);
            end
        end
        for (int i = 0; i < 16; i++) begin
            o[127-8*i -: 8] = t[i] ^ rk[127-8*i -: 8];
        end
        return o;
    endfunction

endpackage

[rtl/ipcpfx_ctrl.sv]
// Controller for the prefix-preserving address cipher: sequences key check,
// bit steps and AES rounds. Depends on ipcpfx_pkg.
module ipcpfx_ctrl import ipcpfx_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_tvalid,
    output logic s_tready,
    input  logic m_tready,
    input  sts_t sts,
    output cmd_t cmd
);

    state_t     state_reg, state_next;
    logic [3:0] cnt_reg, cnt_next;
    logic [7:0] bits_reg, bits_next;

    // state and counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            bits_reg  <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            bits_reg  <= bits_next;
        end
    end

    // next state and commands
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        bits_next  = bits_reg;
        s_tready   = 1'b0;
        cmd.op     = OP_NONE;
        cmd.rnd    = cnt_reg;
        cmd.last   = (cnt_reg == LAST_ROUND);
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.op     = OP_LOAD;
                    cnt_next   = '0;
                    state_next = ST_PREP;
                end
            end
            ST_PREP: begin
                cmd.op   = OP_KEY;
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == CHECK_ROUND) begin
                    state_next = ST_FIX;
                end
            end
            ST_FIX: begin
                cmd.op     = OP_FIX;
                bits_next  = sts.mapped ? STEPS_V4 : STEPS_V6;
                state_next = ST_START;
            end
            ST_START: begin
                cmd.op     = OP_START;
                cnt_next   = '0;
                state_next = ST_ROUND;
            end
            ST_ROUND: begin
                cmd.op   = OP_ROUND;
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == LAST_ROUND) begin
                    state_next = ST_BITS;
                end
            end
            ST_BITS: begin
                cmd.op     = OP_BIT;
                bits_next  = bits_reg - 8'd1;
                state_next = (bits_reg == 8'd1) ? ST_FINISH : ST_START;
            end
            ST_FINISH: begin
                // hold until the output register is free
                if (!sts.out_valid || m_tready) begin
                    cmd.op     = OP_OUT;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    a_accept_prep: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg == ST_PREP))
        else $error("accepted beat did not start key check");
    a_round_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ROUND && cnt_reg == LAST_ROUND) |=> (state_reg == ST_BITS))
        else $error("round sequence did not end in a bit step");
    a_bits_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_BITS) |-> (bits_reg != 8'd0))
        else $error("bit step with no steps left");
    a_out_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == OP_OUT) |-> (!sts.out_valid || m_tready))
        else $error("output overwritten while held");

endmodule

[rtl/ipcpfx_dp.sv]
// Datapath for the prefix-preserving address cipher: two AES-128 lanes with
// on-the-fly key schedule, address walk and output register. Depends on ipcpfx_pkg.
module ipcpfx_dp import ipcpfx_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  cmd_t         cmd,
    output sts_t         sts,
    input  logic [255:0] keys,
    input  logic [127:0] s_tdata,   // address_high [63:0], address_low [127:64]
    input  logic         s_tuser,   // command
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata    // result_high [63:0], result_low [127:64]
);

    logic         cmd_reg;
    logic         mapped_reg;
    logic [127:0] work_reg;
    logic [127:0] res_reg;
    logic [127:0] p_reg;
    logic [127:0] k1_reg, k2_reg;
    logic [127:0] rk1_reg, rk2_reg;
    logic [127:0] st1_reg, st2_reg;
    logic [127:0] out_reg;
    logic         out_valid_reg;

    logic [127:0] addr;
    logic         in_mapped;
    logic [127:0] rk1_new, rk2_new;
    logic         a_bit, c_bit, r_bit;

    assign addr      = {s_tdata[63:0], s_tdata[127:64]};
    assign in_mapped = (addr[127:64] == 64'd0) && (addr[63:32] == V4_MARK);
    assign rk1_new   = key_next(rk1_reg, cmd.rnd);
    assign rk2_new   = key_next(rk2_reg, cmd.rnd);
    assign a_bit     = work_reg[127];
    assign c_bit     = st1_reg[0] ^ st2_reg[0];
    assign r_bit     = a_bit ^ c_bit;

    // walk registers and AES lanes
    always_ff @(posedge aclk) begin
        case (cmd.op)
            OP_LOAD: begin
                cmd_reg    <= s_tuser;
                mapped_reg <= in_mapped;
                work_reg   <= in_mapped ? {addr[31:0], 96'd0} : addr;
                p_reg      <= in_mapped ? P_INIT_V4 : P_INIT_V6;
                res_reg    <= '0;
                k1_reg     <= keys[255:128];
                k2_reg     <= keys[127:0];
                rk1_reg    <= keys[255:128];
                rk2_reg    <= keys[127:0];
            end
            OP_KEY: begin
                rk1_reg <= rk1_new;
                rk2_reg <= rk2_new;
            end
            OP_FIX: begin
                if (rk1_reg == rk2_reg) begin
                    k2_reg <= k1_reg ^ {16{KEY_TWEAK}};
                end
            end
            OP_START: begin
                st1_reg <= p_reg ^ k1_reg;
                st2_reg <= p_reg ^ k2_reg;
                rk1_reg <= k1_reg;
                rk2_reg <= k2_reg;
            end
            OP_ROUND: begin
                rk1_reg <= rk1_new;
                rk2_reg <= rk2_new;
                st1_reg <= aes_round(st1_reg, rk1_new, cmd.last);
                st2_reg <= aes_round(st2_reg, rk2_new, cmd.last);
            end
            OP_BIT: begin
                res_reg  <= {res_reg[126:0], r_bit};
                work_reg <= {work_reg[126:0], 1'b0};
                p_reg    <= {p_reg[126:0], cmd_reg ? r_bit : a_bit};
            end
            OP_OUT: begin
                out_reg <= mapped_reg ? {64'd0, V4_MARK, res_reg[31:0]} : res_reg;
            end
            default: ;
        endcase
    end

    // output beat valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.op == OP_OUT) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    assign sts.mapped    = mapped_reg;
    assign sts.out_valid = out_valid_reg;
    assign m_tvalid      = out_valid_reg;
    assign m_tdata       = {out_reg[63:0], out_reg[127:64]};

endmodule

[rtl/prefix_preserving_ip_cipher_unit.sv]
// Top level of the prefix-preserving address cipher: APB key registers,
// controller and datapath. Depends on ipcpfx_pkg, ipcpfx_ctrl, ipcpfx_dp.
//
//  channel  | direction | handshake            | content
//  s_       | in        | s_tvalid / s_tready  | address beat, command in tuser
//  m_       | out       | m_tvalid / m_tready  | result address beat
//  APB      | in        | psel/penable/pready  | four 64-bit key registers at 8*i
//
// One beat is loaded, run through the key check and key fix, then takes n bit
// steps, n = 32 for IPv4-mapped addresses and 128 otherwise, and is output;
// each bit step runs the ten AES rounds, one round per cycle in both lanes.
// Reset is synchronous on aresetn and clears control state and the key registers only.
// A held result does not block the next beat; a finished beat waits for
// the output register to drain.
module prefix_preserving_ip_cipher_unit import ipcpfx_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,   // address_high [63:0], address_low [127:64]
    input  logic         s_tuser,   // command
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata,   // result_high [63:0], result_low [127:64]
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [63:0]  pwdata,
    output logic [63:0]  prdata,
    output logic         pready
);

    logic [63:0] key_reg [4];
    logic [1:0]  widx;
    cmd_t        cmd;
    sts_t        sts;

    assign widx   = paddr[4:3];
    assign pready = 1'b1;

    // write key registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 4; i++) begin
                key_reg[i] <= '0;
            end
        end else if (psel && penable && pwrite) begin
            key_reg[widx] <= pwdata;
        end
    end

    assign prdata = key_reg[widx];

    ipcpfx_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    ipcpfx_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .sts      (sts),
        .keys     ({key_reg[0], key_reg[1], key_reg[2], key_reg[3]}),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
